### rtl/slcw_pkg.sv
// shared types and constants of the spi display command writer
`default_nettype none

package slcw_pkg;

    // coordinate width; sums wrap at this width, words always go out as 16 bits
    localparam int COORD_BITS = 16;
    localparam int WORD_BITS  = 16;
    localparam int BYTE_BITS  = 8;
    localparam int BIT_CNT_BITS = $clog2(BYTE_BITS);

    localparam int FUNC_BITS   = 2;
    localparam int ORIENT_BITS = 2;
    localparam int OFFSET_BITS = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIENT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET = 1'd1;

    localparam logic [ORIENT_BITS-1:0] ORIENT_RESET = 2'd0;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 8'h3c;

    localparam logic [BYTE_BITS-1:0] CMD_COL_SET   = 8'h2a;
    localparam logic [BYTE_BITS-1:0] CMD_ROW_SET   = 8'h2b;
    localparam logic [BYTE_BITS-1:0] CMD_MEM_WRITE = 8'h2c;

    // frame slots within one request
    localparam int SLOT_BITS = 4;
    localparam logic [SLOT_BITS-1:0] SLOT_FIRST    = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_WORD_HI  = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_WORD_LO  = 4'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_COL_CMD  = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_C0_HI    = 4'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_C0_LO    = 4'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_C1_HI    = 4'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_C1_LO    = 4'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_ROW_CMD  = 4'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_R0_HI    = 4'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_R0_LO    = 4'd7;
    localparam logic [SLOT_BITS-1:0] SLOT_R1_HI    = 4'd8;
    localparam logic [SLOT_BITS-1:0] SLOT_R1_LO    = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_MEM_CMD  = 4'd10;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_CMD_BYTE  = 2'd0,
        FN_DATA_BYTE = 2'd1,
        FN_DATA_WORD = 2'd2,
        FN_WINDOW    = 2'd3
    } t_func;

    typedef enum logic {
        SQ_IDLE,
        SQ_SEND
    } t_seq_state;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_SHIFT,
        SH_DONE
    } t_shift_state;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 cmd;
        logic                 last;
    } t_frame;

endpackage

`default_nettype wire

### rtl/slcw_req_if.sv
// request channel: one display write request per transaction
`default_nettype none

interface slcw_req_if;
    logic                             valid;
    logic                             ready;
    logic [slcw_pkg::FUNC_BITS-1:0]   func;
    logic [15:0]                      value;
    logic [15:0]                      col_start;
    logic [15:0]                      row_start;
    logic [15:0]                      col_end;
    logic [15:0]                      row_end;

    modport source (
        output valid, func, value, col_start, row_start, col_end, row_end,
        input  ready
    );
    modport sink (
        input  valid, func, value, col_start, row_start, col_end, row_end,
        output ready
    );
endinterface

`default_nettype wire

### rtl/slcw_frm_if.sv
// frame channel: one spi byte frame per transaction
`default_nettype none

interface slcw_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_command;
    logic       last;

    modport source (
        output valid, frame_byte, is_command, last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, is_command, last,
        output ready
    );
endinterface

`default_nettype wire

### rtl/slcw_seq.sv
// request sequencer: latches a request and hands out its frames one by one
`default_nettype none

module slcw_seq (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire [slcw_pkg::ORIENT_BITS-1:0]        i_orient,
    input  wire [slcw_pkg::OFFSET_BITS-1:0]        i_offset,
    slcw_req_if.sink                               i_req,
    output slcw_pkg::t_frame                       o_frame,
    output logic                                   o_frame_valid,
    input  wire                                    i_frame_ready
);
    import slcw_pkg::*;

    t_seq_state r_state, n_state;
    t_func                  r_func;
    logic [WORD_BITS-1:0]   r_value;
    logic [COORD_BITS-1:0]  r_c0, r_c1, r_r0, r_r1;
    logic [SLOT_BITS-1:0]   r_slot, r_last_slot;

    logic                   w_accept;
    logic                   w_adv;
    logic [COORD_BITS-1:0]  w_c0_in, w_c1_in, w_r0_in, w_r1_in;
    logic [COORD_BITS-1:0]  w_off;
    logic [WORD_BITS-1:0]   w_c0, w_c1, w_r0, w_r1;
    logic [SLOT_BITS-1:0]   w_last_slot;

    assign w_off = COORD_BITS'(i_offset);

    // orientations 0 and 1 shift the columns, 2 and 3 the rows
    always_comb begin
        w_c0_in = i_req.col_start[COORD_BITS-1:0];
        w_c1_in = i_req.col_end[COORD_BITS-1:0];
        w_r0_in = i_req.row_start[COORD_BITS-1:0];
        w_r1_in = i_req.row_end[COORD_BITS-1:0];
        if (!i_orient[1]) begin
            w_c0_in = w_c0_in + w_off;
            w_c1_in = w_c1_in + w_off;
        end else begin
            w_r0_in = w_r0_in + w_off;
            w_r1_in = w_r1_in + w_off;
        end
    end

    always_comb begin
        case (t_func'(i_req.func))
            FN_DATA_WORD: w_last_slot = SLOT_WORD_LO;
            FN_WINDOW:    w_last_slot = SLOT_MEM_CMD;
            default:      w_last_slot = SLOT_FIRST;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: begin
                if (i_req.valid) begin
                    n_state = SQ_SEND;
                end
            end
            SQ_SEND: begin
                if (i_frame_ready && (r_slot == r_last_slot)) begin
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready   = 1'b0;
        o_frame_valid = 1'b0;
        case (r_state)
            SQ_IDLE: i_req.ready   = 1'b1;
            SQ_SEND: o_frame_valid = 1'b1;
            default: ;
        endcase
    end

    assign w_accept = i_req.valid && i_req.ready;
    assign w_adv    = o_frame_valid && i_frame_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_slot  <= SLOT_FIRST;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_slot <= SLOT_FIRST;
            end else if (w_adv) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func      <= t_func'(i_req.func);
            r_value     <= i_req.value;
            r_c0        <= w_c0_in;
            r_c1        <= w_c1_in;
            r_r0        <= w_r0_in;
            r_r1        <= w_r1_in;
            r_last_slot <= w_last_slot;
        end
    end

    assign w_c0 = WORD_BITS'(r_c0);
    assign w_c1 = WORD_BITS'(r_c1);
    assign w_r0 = WORD_BITS'(r_r0);
    assign w_r1 = WORD_BITS'(r_r1);

    // frame content for the current slot
    always_comb begin
        o_frame.data = r_value[BYTE_BITS-1:0];
        o_frame.cmd  = 1'b0;
        o_frame.last = (r_slot == r_last_slot);
        case (r_func)
            FN_CMD_BYTE: o_frame.cmd = 1'b1;
            FN_DATA_BYTE: ;
            FN_DATA_WORD: begin
                if (r_slot == SLOT_WORD_HI) begin
                    o_frame.data = r_value[WORD_BITS-1:BYTE_BITS];
                end
            end
            FN_WINDOW: begin
                case (r_slot)
                    SLOT_COL_CMD: begin
                        o_frame.data = CMD_COL_SET;
                        o_frame.cmd  = 1'b1;
                    end
                    SLOT_C0_HI: o_frame.data = w_c0[WORD_BITS-1:BYTE_BITS];
                    SLOT_C0_LO: o_frame.data = w_c0[BYTE_BITS-1:0];
                    SLOT_C1_HI: o_frame.data = w_c1[WORD_BITS-1:BYTE_BITS];
                    SLOT_C1_LO: o_frame.data = w_c1[BYTE_BITS-1:0];
                    SLOT_ROW_CMD: begin
                        o_frame.data = CMD_ROW_SET;
                        o_frame.cmd  = 1'b1;
                    end
                    SLOT_R0_HI: o_frame.data = w_r0[WORD_BITS-1:BYTE_BITS];
                    SLOT_R0_LO: o_frame.data = w_r0[BYTE_BITS-1:0];
                    SLOT_R1_HI: o_frame.data = w_r1[WORD_BITS-1:BYTE_BITS];
                    SLOT_R1_LO: o_frame.data = w_r1[BYTE_BITS-1:0];
                    default: begin
                        o_frame.data = CMD_MEM_WRITE;
                        o_frame.cmd  = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/slcw_ser.sv
// bit serializer: shifts each byte msb first over the serial line and captures it
`default_nettype none

module slcw_ser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  slcw_pkg::t_frame    i_frame,
    input  wire                 i_frame_valid,
    output logic                o_frame_ready,
    slcw_frm_if.source          o_frm
);
    import slcw_pkg::*;

    t_shift_state r_state, n_state;
    logic [BYTE_BITS-1:0]    r_tx, r_rx;
    logic [BIT_CNT_BITS-1:0] r_bit_cnt;
    logic                    r_cmd, r_last;
    logic                    r_out_valid;
    logic [BYTE_BITS-1:0]    r_out_byte;
    logic                    r_out_cmd, r_out_last;

    logic w_load, w_shift, w_out_load, w_sdo, w_bit_done;

    assign w_sdo      = r_tx[BYTE_BITS-1];
    assign w_bit_done = (r_bit_cnt == BIT_CNT_BITS'(BYTE_BITS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SH_IDLE: begin
                if (i_frame_valid) begin
                    n_state = SH_SHIFT;
                end
            end
            SH_SHIFT: begin
                if (w_bit_done) begin
                    n_state = SH_DONE;
                end
            end
            SH_DONE: begin
                if (!r_out_valid || o_frm.ready) begin
                    n_state = SH_IDLE;
                end
            end
            default: n_state = SH_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_frame_ready = 1'b0;
        w_shift       = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            SH_IDLE:  o_frame_ready = 1'b1;
            SH_SHIFT: w_shift       = 1'b1;
            SH_DONE:  w_out_load    = !r_out_valid || o_frm.ready;
            default: ;
        endcase
    end

    assign w_load = i_frame_valid && o_frame_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SH_IDLE;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_bit_cnt <= '0;
            end else if (w_shift) begin
                r_bit_cnt <= r_bit_cnt + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_frm.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tx   <= i_frame.data;
            r_cmd  <= i_frame.cmd;
            r_last <= i_frame.last;
        end else if (w_shift) begin
            r_tx <= {r_tx[BYTE_BITS-2:0], 1'b0};
        end
        // receive side of the line, as a loopback of the transmitted bit
        if (w_shift) begin
            r_rx <= {r_rx[BYTE_BITS-2:0], w_sdo};
        end
        if (w_out_load) begin
            r_out_byte <= r_rx;
            r_out_cmd  <= r_cmd;
            r_out_last <= r_last;
        end
    end

    assign o_frm.valid      = r_out_valid;
    assign o_frm.frame_byte = r_out_byte;
    assign o_frm.is_command = r_out_cmd;
    assign o_frm.last       = r_out_last;

endmodule

`default_nettype wire

### rtl/spi_lcd_command_writer.sv
// spi display command writer: display write requests in, spi byte frames out
//
// i_req carries one request per transaction: a command byte, a data byte, a
// 16-bit data word (high byte first) or a window set (0x2a, column bounds,
// 0x2b, row bounds, 0x2c). o_frm carries one byte frame per transaction with
// its command flag; last marks the final frame of the request.
// The configuration port writes orientation (index 0) and panel offset
// (index 1) whenever i_cfg_we is high. The offset is added to the column
// bounds in orientations 0 and 1 and to the row bounds in 2 and 3.
// Each frame is shifted out one bit per cycle: load, eight shifts and a
// move into the output register. A request produces one, two or eleven
// frames. A new request is taken once the last frame of the previous one
// has left the sequencer. The first frame passes the sequencer registers,
// then the serializer's shift register and its output register.
// A stalled receiver holds the output register; the next frame waits fully
// shifted behind it and the sequencer waits behind that.
// Reset sets orientation to 0, the offset to 0x3c and empties all stages.
`default_nettype none

module spi_lcd_command_writer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [slcw_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire [slcw_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    slcw_req_if.sink                            i_req,
    slcw_frm_if.source                          o_frm
);
    import slcw_pkg::*;

    logic [ORIENT_BITS-1:0] r_orient;
    logic [OFFSET_BITS-1:0] r_offset;

    t_frame w_frame;
    logic   w_frame_valid;
    logic   w_frame_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= ORIENT_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIENT: r_orient <= i_cfg_data[ORIENT_BITS-1:0];
                REG_OFFSET: r_offset <= i_cfg_data[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    slcw_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_orient      (r_orient),
        .i_offset      (r_offset),
        .i_req         (i_req),
        .o_frame       (w_frame),
        .o_frame_valid (w_frame_valid),
        .i_frame_ready (w_frame_ready)
    );

    slcw_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_frame),
        .i_frame_valid (w_frame_valid),
        .o_frame_ready (w_frame_ready),
        .o_frm         (o_frm)
    );

`ifndef ASSERT_OFF
    // an accepted request keeps the sequencer busy for at least one frame
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request ready right after accept");

    // the sequencer never offers a frame while it waits for a request
    a_no_frame_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !w_frame_valid)
        else $error("frame offered while idle");

    // handing over the last frame frees the request channel
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_frame_valid && w_frame_ready && w_frame.last) |=> i_req.ready)
        else $error("request channel not free after last frame");

    // a non-last frame always has a successor
    a_more_after_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_frame_valid && w_frame_ready && !w_frame.last) |=> w_frame_valid)
        else $error("request ended without last frame");
`endif

endmodule

`default_nettype wire
